@@ hw/rtl/xs128bd_pkg.sv @@
package xs128bd_pkg;

    // Word width of the generator and of every payload field
    localparam int WORD_W = 32;

    // Default depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Seed load constants
    localparam logic [WORD_W-1:0] SEED_XOR_0 = 32'haffeaffe;
    localparam logic [WORD_W-1:0] SEED_XOR_1 = 32'hf9b2a750;
    localparam logic [WORD_W-1:0] SEED_XOR_2 = 32'h485eac66;
    localparam logic [WORD_W-1:0] SEED_XOR_3 = 32'hcbd02714;
    localparam logic [WORD_W-1:0] SEED_OFS_3 = 32'd263083;

    // Xorshift shift amounts
    localparam int SHL_A = 11;
    localparam int SHR_B = 19;
    localparam int SHR_C = 8;

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = WORD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // One queued draw, classified by the front part
    typedef struct packed {
        logic [WORD_W-1:0] raw_word;
        logic [WORD_W-1:0] lower_bound;
        logic [WORD_W-1:0] interval;
        logic              range_error;
    } entry_t;

    // Generator state
    typedef struct packed {
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w0;
    } gen_state_t;

    // State words loaded from a seed
    function automatic gen_state_t seed_load(input logic [WORD_W-1:0] s);
        gen_state_t g;
        g.w0 = SEED_XOR_0 ^ s;
        g.w1 = SEED_XOR_1 ^ (s + 32'd1);
        g.w2 = SEED_XOR_2 ^ (s - 32'd1);
        g.w3 = SEED_XOR_3 ^ (s + SEED_OFS_3);
        return g;
    endfunction

    // One xorshift step
    function automatic gen_state_t gen_advance(input gen_state_t g);
        gen_state_t        n;
        logic [WORD_W-1:0] t;
        t    = g.w0 ^ (g.w0 << SHL_A);
        n.w0 = g.w1;
        n.w1 = g.w2;
        n.w2 = g.w3;
        n.w3 = g.w3 ^ (g.w3 >> SHR_B) ^ t ^ (t >> SHR_C);
        return n;
    endfunction

endpackage

@@ hw/rtl/xs128bd_front.sv @@
module xs128bd_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               seed_we,
    input  logic [xs128bd_pkg::WORD_W-1:0]     seed,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [xs128bd_pkg::WORD_W-1:0]     lower_bound,
    input  logic [xs128bd_pkg::WORD_W-1:0]     upper_bound,
    input  logic                               q_full,
    output logic                               push,
    output xs128bd_pkg::entry_t                push_entry
);

    xs128bd_pkg::gen_state_t gen_reg;
    xs128bd_pkg::gen_state_t gen_next;
    xs128bd_pkg::gen_state_t gen_adv;
    logic [xs128bd_pkg::WORD_W-1:0] interval;

    // Accept a word whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // Advanced state and interval classification
    assign gen_adv  = xs128bd_pkg::gen_advance(gen_reg);
    assign interval = upper_bound - lower_bound + 32'd1;

    always_comb
    begin
        push_entry.raw_word    = gen_adv.w3;
        push_entry.lower_bound = lower_bound;
        push_entry.interval    = interval;
        push_entry.range_error = (interval == '0);
    end

    // Seed reload takes priority; otherwise step on each accepted word
    always_comb
    begin
        gen_next = gen_reg;
        if (seed_we)
        begin
            gen_next = xs128bd_pkg::seed_load(seed);
        end
        else if (push)
        begin
            gen_next = gen_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= xs128bd_pkg::seed_load('0);
        end
        else
        begin
            gen_reg <= gen_next;
        end
    end

endmodule

@@ hw/rtl/xs128bd_queue.sv @@
module xs128bd_queue #(
    parameter int DEPTH = xs128bd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  xs128bd_pkg::entry_t  push_entry,
    input  logic                 pop,
    output xs128bd_pkg::entry_t  pop_entry,
    output logic                 q_full,
    output logic                 q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    xs128bd_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign q_full    = (count_reg == CNT_W'(DEPTH));
    assign q_empty   = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/xs128bd_back.sv @@
module xs128bd_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  xs128bd_pkg::entry_t                pop_entry,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [xs128bd_pkg::WORD_W-1:0]     raw_word,
    output logic [xs128bd_pkg::WORD_W-1:0]     bounded_value,
    output logic                               range_error
);

    localparam int W = xs128bd_pkg::WORD_W;
    localparam int SW = xs128bd_pkg::STEP_W;
    localparam logic [SW-1:0] LAST_STEP = SW'(xs128bd_pkg::DIV_STEPS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvd_reg, dvd_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [W-1:0] lo_reg,  lo_next;
    logic         err_reg, err_next;

    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_raw_reg, out_raw_next;
    logic [W-1:0] out_bnd_reg, out_bnd_next;
    logic         out_err_reg, out_err_next;

    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] rem_step;
    logic         load_out;

    // Restoring remainder step: shift in one dividend bit, subtract if it fits
    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign rem_step = fits ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        lo_next    = lo_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next   = ST_RUN;
                    step_next    = '0;
                    rem_next     = '0;
                    dvd_next     = pop_entry.raw_word;
                    dvs_next     = pop_entry.interval;
                    lo_next      = pop_entry.lower_bound;
                    err_next     = pop_entry.range_error;
                end
            end
            ST_RUN:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register; raw word kept in its own hold register until the result loads
    logic [W-1:0] raw_hold_reg, raw_hold_next;

    always_comb
    begin
        raw_hold_next = pop ? pop_entry.raw_word : raw_hold_reg;
        out_bnd_next  = out_bnd_reg;
        out_err_next  = out_err_reg;
        out_raw_next  = out_raw_reg;
        if (load_out)
        begin
            out_raw_next = raw_hold_reg;
            out_bnd_next = err_reg ? lo_reg : lo_reg + rem_reg;
            out_err_next = err_reg;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        lo_reg       <= lo_next;
        err_reg      <= err_next;
        raw_hold_reg <= raw_hold_next;
        out_raw_reg  <= out_raw_next;
        out_bnd_reg  <= out_bnd_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid     = out_valid_reg;
    assign raw_word      = out_raw_reg;
    assign bounded_value = out_bnd_reg;
    assign range_error   = out_err_reg;

endmodule

@@ hw/rtl/xorshift128_bounded_integer_draw.sv @@
// Channel   Handshake            Word
// -------   ------------------   ----------------------------------------
// in        in_valid/in_ready    lower_bound, upper_bound (signed)
// out       out_valid/out_ready  raw_word, bounded_value, range_error
// seed      seed_we              seed (reloads the generator state)
//
// The front steps the generator and queues a word in the cycle it is taken.
// The back reduces each word with a shared restoring divider, one remainder
// bit a cycle (pop, 32 division steps, result load), and takes no new word
// until that result has loaded. The queue keeps the front taking words
// while the back divides or the output waits. rst_n clears all control and
// loads the state for seed zero; no clearing pass is needed.
module xorshift128_bounded_integer_draw #(
    parameter int QUEUE_DEPTH = xs128bd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   seed_we,
    input  logic [xs128bd_pkg::WORD_W-1:0]         seed,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [xs128bd_pkg::WORD_W-1:0]  lower_bound,
    input  logic signed [xs128bd_pkg::WORD_W-1:0]  upper_bound,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [xs128bd_pkg::WORD_W-1:0]         raw_word,
    output logic signed [xs128bd_pkg::WORD_W-1:0]  bounded_value,
    output logic                                   range_error
);

    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    xs128bd_pkg::entry_t  push_entry;
    xs128bd_pkg::entry_t  pop_entry;
    logic [xs128bd_pkg::WORD_W-1:0] bnd;

    // Front: generator and classification
    xs128bd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_we     (seed_we),
        .seed        (seed),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lower_bound ($unsigned(lower_bound)),
        .upper_bound ($unsigned(upper_bound)),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Queue between the two parts
    xs128bd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_full     (q_full),
        .q_empty    (q_empty)
    );

    // Back: modulo reduction and output register
    xs128bd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_word      (raw_word),
        .bounded_value (bnd),
        .range_error   (range_error)
    );

    assign bounded_value = $signed(bnd);

    // Checks
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("word queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("word popped from empty queue");

    a_div_takes_time: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !pop)
        else $error("back part popped on consecutive cycles");

    a_err_forces_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_entry.range_error) |-> (push_entry.interval == '0))
        else $error("range error without zero interval");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int W = xs128bd_pkg::WORD_W;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_DRAWS = 300;
    localparam logic [W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [W-1:0] INT_MAX = 32'h7fff_ffff;

    // Directed bounds: full range, single value, widest intervals, reversed
    localparam int NUM_DIR = 19;
    localparam logic [W-1:0] DIR_LO [NUM_DIR] = '{
        INT_MIN, 32'h0, 32'h0, INT_MIN, INT_MAX, 32'h0, INT_MIN, 32'h0,
        32'hffff_ffff, INT_MAX, 32'd10, 32'hffff_fffb, 32'd1, 32'haaaa_aaaa,
        32'h5555_5555, INT_MIN, 32'hffff_ffff, 32'h0, 32'd100
    };
    localparam logic [W-1:0] DIR_HI [NUM_DIR] = '{
        INT_MAX, 32'hffff_ffff, 32'h0, INT_MIN, INT_MAX, 32'hffff_fffe,
        32'hffff_ffff, INT_MAX, 32'h0, INT_MIN, 32'hffff_fff6, 32'd5, 32'd6,
        32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'hffff_ffff, 32'd1, 32'd99
    };

    // Seeds per phase; the last phase takes a random one
    localparam int NUM_SEEDS = 5;
    localparam logic [W-1:0] SEED_LIST [NUM_SEEDS] = '{
        32'hffff_ffff, 32'h0000_0000, 32'hfffb_fc55, 32'h0000_0001, 32'h5a5a_5a5a
    };

    typedef struct packed {
        logic [W-1:0] raw;
        logic [W-1:0] bounded;
        logic         flag;
    } draw_result_t;

    // Generator mirror and queue of awaited draw results
    class draw_scoreboard;
        logic [W-1:0] gen_w [4];
        draw_result_t awaited [$];
        int           errors;
        int           checked;
        int           flagged;
        int           reloads;

        function new();
            errors  = 0;
            checked = 0;
            flagged = 0;
            reload(0);
            reloads = 0;
        endfunction

        // Seed write: all four state words reloaded
        function void reload(logic [W-1:0] s);
            gen_w[0] = xs128bd_pkg::SEED_XOR_0 ^ s;
            gen_w[1] = xs128bd_pkg::SEED_XOR_1 ^ (s + 32'd1);
            gen_w[2] = xs128bd_pkg::SEED_XOR_2 ^ (s - 32'd1);
            gen_w[3] = xs128bd_pkg::SEED_XOR_3 ^ (s + xs128bd_pkg::SEED_OFS_3);
            reloads++;
        endfunction

        // One accepted request: step the generator and reduce the word
        function void note_draw(logic [W-1:0] lo, logic [W-1:0] hi);
            logic [W-1:0] t;
            logic [W-1:0] span;
            draw_result_t e;
            t = gen_w[0] ^ (gen_w[0] << xs128bd_pkg::SHL_A);
            e.raw = gen_w[3] ^ (gen_w[3] >> xs128bd_pkg::SHR_B) ^ t
                    ^ (t >> xs128bd_pkg::SHR_C);
            gen_w[0] = gen_w[1];
            gen_w[1] = gen_w[2];
            gen_w[2] = gen_w[3];
            gen_w[3] = e.raw;
            span = hi - lo + 32'd1;
            // interval wrapped to zero: lower bound returned, error raised
            if (span == '0)
            begin
                e.bounded = lo;
                e.flag    = 1'b1;
            end
            else
            begin
                e.bounded = lo + (e.raw % span);
                e.flag    = 1'b0;
            end
            awaited.push_back(e);
        endfunction

        function void check_draw(logic [W-1:0] raw, logic [W-1:0] bounded, logic flag);
            draw_result_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected word raw %h bounded %h flag %b",
                         $time, raw, bounded, flag);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (e.flag)
                flagged++;
            if (raw !== e.raw)
            begin
                $display("%0t: raw_word expected %h actual %h", $time, e.raw, raw);
                errors++;
            end
            if (bounded !== e.bounded)
            begin
                $display("%0t: bounded_value expected %h actual %h",
                         $time, e.bounded, bounded);
                errors++;
            end
            if (flag !== e.flag)
            begin
                $display("%0t: range_error expected %b actual %b", $time, e.flag, flag);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         seed_we;
    logic [W-1:0] seed;
    logic         in_valid;
    logic         in_ready;
    logic [W-1:0] lower_bound;
    logic [W-1:0] upper_bound;
    logic         out_valid;
    logic         out_ready;
    logic [W-1:0] raw_word;
    logic [W-1:0] bounded_value;
    logic         range_error;

    draw_scoreboard sb = new();
    int             quiet;
    int             sent;
    int unsigned    rx_mode;
    int unsigned    rx_left;
    logic [5:0]     rx_phase;

    xorshift128_bounded_integer_draw u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_we       (seed_we),
        .seed          (seed),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .lower_bound   (lower_bound),
        .upper_bound   (upper_bound),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .raw_word      (raw_word),
        .bounded_value (bounded_value),
        .range_error   (range_error)
    );

    always #10 clk = ~clk;

    // Monitor: results checked before the same edge's request is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_draw(raw_word, bounded_value, range_error);
            if (seed_we)
                sb.reload(seed);
            if (in_valid && in_ready)
                sb.note_draw(lower_bound, upper_bound);
        end
    end

    // Receiver: pattern switches between free flow, coin toss, sparse, long stalls
    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 6'd1;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 300);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (rx_phase >= 6'd60);
        endcase
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: errors");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Present one request and hold it until taken; valid stays high afterwards
    task automatic send_draw(input logic [W-1:0] lo, input logic [W-1:0] hi);
        lower_bound <= lo;
        upper_bound <= hi;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic idle_for(input int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drops valid and waits until the monitor has noted the last accepted request and its result has returned
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [W-1:0] v);
        seed    <= v;
        seed_we <= 1'b1;
        @(posedge clk);
        seed_we <= 1'b0;
    endtask

    // Random bounds, weighted towards narrow intervals with some wide, wrapped and reversed
    task automatic pick_bounds(output logic [W-1:0] lo, output logic [W-1:0] hi);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        lo   = $urandom;
        case (pick)
            0, 1, 2: hi = lo + $urandom_range(0, 15);
            3:       hi = lo + $urandom_range(0, 65535);
            4, 5:    hi = $urandom;
            6:       hi = lo - 32'd1;
            7:       hi = lo;
            8:
            begin
                lo = -$urandom_range(0, 100);
                hi = $urandom_range(0, 100);
            end
            default: hi = lo - $urandom_range(2, 1000);
        endcase
    endtask

    initial
    begin
        logic [W-1:0] lo;
        logic [W-1:0] hi;
        int unsigned  burst;
        int unsigned  gap;
        int unsigned  pick;

        clk         = 1'b0;
        rst_n       = 1'b0;
        seed_we     = 1'b0;
        seed        = '0;
        in_valid    = 1'b0;
        lower_bound = '0;
        upper_bound = '0;
        out_ready   = 1'b0;
        rx_mode     = 0;
        rx_left     = 0;
        rx_phase    = '0;
        quiet       = 0;
        sent        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners on the reset seed
        for (int i = 0; i < NUM_DIR; i++)
        begin
            send_draw(DIR_LO[i], DIR_HI[i]);
            if (i % 4 == 3)
                idle_for($urandom_range(1, 40));
        end
        drain();

        // Random phases, each after a fresh seed
        for (int p = 0; p <= NUM_SEEDS; p++)
        begin
            write_seed(p < NUM_SEEDS ? SEED_LIST[p] : W'($urandom));
            for (int n = 0; n < PHASE_DRAWS; )
            begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < PHASE_DRAWS; b++)
                begin
                    pick_bounds(lo, hi);
                    send_draw(lo, hi);
                    n++;
                end
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    gap = 0;
                else if (pick == 9)
                    gap = $urandom_range(20, 70);
                else
                    gap = $urandom_range(1, 12);
                if (gap != 0)
                    idle_for(gap);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (sb.awaited.size() != 0)
        begin
            $display("%0t: %0d draws never returned", $time, sb.awaited.size());
            sb.errors++;
        end
        $display("%0d requests sent, %0d results checked across %0d seed loads",
                 sent, sb.checked, sb.reloads);
        $display("%0d full-range draws raised the range flag", sb.flagged);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
